/* rtl/core/sti_pkg.sv */
// sti_pkg: shared constants and types for the sorted table insert/remove block
// used by sti_cell and sorted_table_insert_remove
`timescale 1ns / 1ps

package sti_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int COUNT_MAX   = (1 << COUNT_OUT_W) - 1;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

/* rtl/core/sti_cell.sv */
// sti_cell: one slot of the sorted table, holding one entry and shifting with its neighbors
// depends on sti_pkg
`timescale 1ns / 1ps

module sti_cell
    import sti_pkg::*;
(
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    occupied,
    input  logic                    left_less,
    input  logic signed [VAL_W-1:0] left_entry,
    input  logic signed [VAL_W-1:0] right_entry,
    output logic                    less,
    output logic                    hit,
    output logic signed [VAL_W-1:0] entry,
    output logic signed [VAL_W-1:0] entry_next
);

    logic signed [VAL_W-1:0] entry_reg;

    assign entry = entry_reg;
    assign less  = occupied && (entry_reg < value);
    // first entry not below the word value, and equal to it
    assign hit   = occupied && !less && left_less && (entry_reg == value);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins_en && !less) begin
            entry_next = left_less ? value : left_entry;
        end else if (ctrl.rem_en && !less) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/sorted_table_insert_remove.sv */
// sorted_table_insert_remove: top level, a row of sti_cell slots kept in ascending order
// depends on sti_pkg and sti_cell
`timescale 1ns / 1ps
//
// channel  dir  handshake           tdata / tuser
// s_       in   s_tvalid/s_tready   tdata: value ; tuser: req_type
// m_       out  m_tvalid/m_tready   tdata: entry_count, table_empty, smallest_value ; tuser: status
//
// one request per cycle while s_tready is high: every cell compares against the word in parallel and
// shifts one place toward or away from the insert/remove point in the same cycle.
// the result is registered and shows in the cycle after acceptance.
// s_tready drops only while a result waits and m_tready is low.
// reset clears the entry count and the output valid; cell contents need no reset.

module sorted_table_insert_remove
    import sti_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [6:0] entry_count, [7] table_empty, [39:8] smallest_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic [39:0]      m_data_reg;
    logic [1:0]       m_user_reg;

    logic signed [VAL_W-1:0] value;
    logic                    accept, full, found;
    cell_ctrl_t              ctrl;
    status_t                 status;

    logic [TABLE_DEPTH-1:0]  less_v, hit_v, occ_v;
    logic signed [VAL_W-1:0] entry_v      [TABLE_DEPTH];
    logic signed [VAL_W-1:0] entry_next_v [TABLE_DEPTH];
    logic [COUNT_OUT_W-1:0]  count_out;
    logic signed [VAL_W-1:0] smallest;

    assign value    = signed'(s_tdata);
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign found    = |hit_v;

    always_comb begin
        ctrl.ins_en = accept && (req_type_t'(s_tuser) == REQ_INSERT) && !full;
        ctrl.rem_en = accept && (req_type_t'(s_tuser) == REQ_REMOVE) && found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic                    l_less;
            logic signed [VAL_W-1:0] l_entry, r_entry;
            assign occ_v[gi] = (CNT_W'(gi) < count_reg);
            if (gi == 0) begin : g_first
                assign l_less  = 1'b1;
                assign l_entry = '0;
            end else begin : g_mid
                assign l_less  = less_v[gi-1];
                assign l_entry = entry_v[gi-1];
            end
            if (gi == TABLE_DEPTH - 1) begin : g_last
                assign r_entry = '0;
            end else begin : g_inner
                assign r_entry = entry_v[gi+1];
            end
            sti_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .value       (value),
                .occupied    (occ_v[gi]),
                .left_less   (l_less),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .less        (less_v[gi]),
                .hit         (hit_v[gi]),
                .entry       (entry_v[gi]),
                .entry_next  (entry_next_v[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.rem_en) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (req_type_t'(s_tuser) == REQ_INSERT) begin
            status = full ? ST_FULL : ST_INSERTED;
        end else begin
            status = found ? ST_REMOVED : ST_NOT_FOUND;
        end
        // saturate when the table is deeper than the count field
        if (CNT_W > COUNT_OUT_W && count_next > CNT_W'(COUNT_MAX)) begin
            count_out = COUNT_OUT_W'(COUNT_MAX);
        end else begin
            count_out = COUNT_OUT_W'(count_next);
        end
        smallest = (count_next == '0) ? '0 : entry_next_v[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {smallest, (count_next == '0), count_out};
            m_user_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* tb/sorted_table_insert_remove_tb.sv */
// sorted_table_insert_remove_tb: self-checking bench for the sorted table insert/remove block
// drives insert/remove words with random gaps and back-pressure and checks every result
// depends on sti_pkg and sorted_table_insert_remove
`timescale 1ns / 1ps

module sorted_table_insert_remove_tb;
    import sti_pkg::*;

    localparam int RANDOM_ITEMS  = 1900;
    localparam int DIRECTED_ROWS = 25;
    localparam int MAX_WAIT      = 8;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     table_empty;
        logic signed [VAL_W-1:0]  smallest_value;
    } table_result_t;

    typedef struct packed {
        req_type_t     op;
        logic [31:0]   value;
        logic          fixed;     // 1: want is typed in, 0: want comes from the table copy
        table_result_t want;
    } directed_row_t;

    typedef enum {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_t;

    localparam table_result_t PREDICTED = '{ST_INSERTED, '0, 1'b0, '0};

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{REQ_REMOVE, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 7'd0, 1'b1, 32'sh0000_0000}},
        '{REQ_INSERT, 32'h7FFF_FFFF, 1'b1, '{ST_INSERTED,  7'd1, 1'b0, 32'sh7FFF_FFFF}},
        '{REQ_INSERT, 32'h8000_0000, 1'b1, '{ST_INSERTED,  7'd2, 1'b0, 32'sh8000_0000}},
        '{REQ_INSERT, 32'hFFFF_FFFF, 1'b0, PREDICTED},
        '{REQ_INSERT, 32'h0000_0000, 1'b0, PREDICTED},
        '{REQ_INSERT, 32'h0000_0000, 1'b0, PREDICTED},
        '{REQ_INSERT, 32'h0000_0001, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h0000_0005, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h8000_0000, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h0000_0000, 1'b0, PREDICTED},
        '{REQ_INSERT, 32'h8000_0000, 1'b0, PREDICTED},
        '{REQ_INSERT, 32'h8000_0001, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h7FFF_FFFE, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h7FFF_FFFF, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h0000_0000, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h0000_0000, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'hFFFF_FFFF, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h0000_0001, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h8000_0001, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h8000_0000, 1'b1, '{ST_REMOVED,   7'd0, 1'b1, 32'sh0000_0000}},
        '{REQ_REMOVE, 32'h8000_0000, 1'b1, '{ST_NOT_FOUND, 7'd0, 1'b1, 32'sh0000_0000}},
        '{REQ_INSERT, 32'hAAAA_AAAA, 1'b0, PREDICTED},
        '{REQ_INSERT, 32'h5555_5555, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'hAAAA_AAAA, 1'b0, PREDICTED},
        '{REQ_REMOVE, 32'h5555_5555, 1'b1, '{ST_REMOVED,   7'd0, 1'b1, 32'sh0000_0000}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] value
    logic        s_tuser  = 1'b0;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [6:0] entry_count, [7] table_empty, [39:8] smallest_value
    logic [1:0]  m_tuser;           // [1:0] status

    // ascending copy of the table contents, duplicates kept
    logic signed [VAL_W-1:0] table_vals [$];
    table_result_t           pending_results [$];
    int                      mismatch_count = 0;
    bit                      s_no_idle = 1'b0;
    bit                      m_no_idle = 1'b0;

    sorted_table_insert_remove i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // updates the table copy for one request and returns the result it should give
    function automatic table_result_t apply_request(input req_type_t op,
                                                    input logic signed [VAL_W-1:0] v);
        table_result_t r;
        int            pos;
        pos = 0;
        while (pos < table_vals.size() && table_vals[pos] < v)
            pos++;
        if (op == REQ_INSERT) begin
            if (table_vals.size() >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // lands in front of any equal entries
                table_vals.insert(pos, v);
                r.status = ST_INSERTED;
            end
        end else if (pos < table_vals.size() && table_vals[pos] == v) begin
            table_vals.delete(pos);
            r.status = ST_REMOVED;
        end else begin
            r.status = ST_NOT_FOUND;
        end
        r.entry_count    = (table_vals.size() > COUNT_MAX) ? COUNT_OUT_W'(COUNT_MAX)
                                                           : COUNT_OUT_W'(table_vals.size());
        r.table_empty    = (table_vals.size() == 0);
        r.smallest_value = (table_vals.size() == 0) ? '0 : table_vals[0];
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input req_type_t op);
        int sel;
        sel = $urandom_range(0, 99);
        if (op == REQ_REMOVE && table_vals.size() > 0 && sel < 60)
            return table_vals[$urandom_range(0, table_vals.size() - 1)];
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 32'(int'($urandom_range(0, 16)) - 8);   // narrow band for duplicates
        if (sel < 85)
            return $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h8000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h7FFF_FFFE;
            4:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic issue_request(input req_type_t op, input logic [31:0] val,
                                 input logic fixed, input table_result_t want);
        int            gap;
        table_result_t predicted;
        gap = s_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        predicted = apply_request(op, val);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // result side: random stalls, check each accepted word against the oldest expectation
    initial begin
        int            stall;
        int            seen;
        table_result_t exp_r;
        seen = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (seen % 64 == 0)
                m_no_idle = ($urandom_range(0, 3) == 0);
            stall = m_no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1)
                @(posedge aclk);
            seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result word tdata=%h tuser=%h",
                                          m_tdata, m_tuser));
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tuser, exp_r.status));
                if (m_tdata[6:0] !== exp_r.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              m_tdata[6:0], exp_r.entry_count));
                if (m_tdata[7] !== exp_r.table_empty)
                    report_mismatch($sformatf("table_empty got %b want %b",
                                              m_tdata[7], exp_r.table_empty));
                if (m_tdata[39:8] !== exp_r.smallest_value)
                    report_mismatch($sformatf("smallest_value got %h want %h",
                                              m_tdata[39:8], exp_r.smallest_value));
            end
        end
    end

    // request side and end of run
    initial begin
        int        issued;
        int        k;
        int        extra;
        int        len;
        int        insert_pct;
        phase_t    phase;
        req_type_t op;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++)
            issue_request(DIRECTED[k].op, DIRECTED[k].value, DIRECTED[k].fixed,
                          DIRECTED[k].want);

        // random phases: fill to full, drain to empty, or a mixed stretch
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            phase      = phase_t'($urandom_range(0, 2));
            insert_pct = (phase == PH_FILL) ? 85 : (phase == PH_DRAIN) ? 15 : 50;
            extra      = $urandom_range(1, 12);
            len        = $urandom_range(40, 120);
            for (k = 0; issued < RANDOM_ITEMS; k++) begin
                if ((phase == PH_FILL && table_vals.size() >= TABLE_DEPTH) ||
                    (phase == PH_DRAIN && table_vals.size() == 0)) begin
                    if (extra == 0)
                        break;
                    extra--;
                end
                if (phase == PH_MIXED && k >= len)
                    break;
                if (issued % 64 == 0)
                    s_no_idle = ($urandom_range(0, 3) == 0);
                op = ($urandom_range(1, 100) <= insert_pct) ? REQ_INSERT : REQ_REMOVE;
                issue_request(op, pick_value(op), 1'b0, PREDICTED);
                issued++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // about ten times the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
